@@ rtl/idq_pkg.sv @@
package idq_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		OP_INSERT    = 2'd0,
		OP_POP_FRONT = 2'd1,
		OP_POP_REAR  = 2'd2,
		OP_PEEK      = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		op_t                        op;
		logic signed [DATA_W-1:0]   data_in;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]   data_out;
		status_t                    status;
		logic                       is_empty;
		logic                       is_full;
	} result_t;

	// request from the pointer logic to the entry store
	typedef struct packed {
		logic                  we;
		logic                  re;
		logic [ADDR_W-1:0]     addr;
		logic [DATA_W-1:0]     wdata;
	} mem_req_t;

	// per-transaction outcome known at accept time
	typedef struct packed {
		logic                  valid;
		logic                  use_mem;
		status_t               status;
		logic                  is_empty;
		logic                  is_full;
	} step_t;

	function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] idx);
		logic [ADDR_W-1:0] r;
		if (idx == ADDR_W'(DEPTH - 1)) r = '0;
		else                           r = idx + ADDR_W'(1);
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] wrap_dec(input logic [ADDR_W-1:0] idx);
		logic [ADDR_W-1:0] r;
		if (idx == '0) r = ADDR_W'(DEPTH - 1);
		else           r = idx - ADDR_W'(1);
		return r;
	endfunction

endpackage

@@ rtl/idq_ram.sv @@
module idq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

@@ rtl/idq_ctrl.sv @@
module idq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  idq_pkg::cmd_t   cmd,
	output idq_pkg::mem_req_t req,
	output idq_pkg::step_t  step
);
	import idq_pkg::*;

	logic [ADDR_W-1:0] head_q, tail_q, head_n, tail_n, tail_dec;
	logic [CNT_W-1:0]  occ_q, occ_n;
	logic              full, empty;

	assign full     = (occ_q == CNT_W'(DEPTH));
	assign empty    = (occ_q == '0);
	assign tail_dec = wrap_dec(tail_q);

	always_comb begin
		head_n       = head_q;
		tail_n       = tail_q;
		occ_n        = occ_q;
		req.we       = 1'b0;
		req.re       = 1'b0;
		req.addr     = head_q;
		req.wdata    = cmd.data_in;
		step.use_mem = 1'b0;
		step.status  = ST_OK;
		if (cmd.op == OP_INSERT) begin
			if (full) begin
				step.status = ST_OVERFLOW;
			end else begin
				req.we   = accept;
				req.addr = tail_q;
				tail_n   = wrap_inc(tail_q);
				occ_n    = occ_q + CNT_W'(1);
			end
		end else if (empty) begin
			step.status = ST_UNDERFLOW;
		end else begin
			req.re       = accept;
			step.use_mem = 1'b1;
			case (cmd.op)
				OP_POP_FRONT: begin
					head_n = wrap_inc(head_q);
					occ_n  = occ_q - CNT_W'(1);
				end
				OP_POP_REAR: begin
					req.addr = tail_dec;
					tail_n   = tail_dec;
					occ_n    = occ_q - CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
		step.valid    = accept;
		step.is_empty = (occ_n == '0);
		step.is_full  = (occ_n == CNT_W'(DEPTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
		end else if (accept) begin
			head_q <= head_n;
			tail_q <= tail_n;
			occ_q  <= occ_n;
		end
	end

endmodule

@@ rtl/input_restricted_deque.sv @@
// the result strobe is registered and comes in the cycle after the accepting edge
// throughput: one transaction per cycle, busy stays low; the single-port entry
// store is touched at most once per transaction, write at accept or read at accept
// reset: asynchronous active-low arst_n empties the queue (head, tail, count)
// and drops any pending result; the entry store itself is not cleared
// the receiver cannot stall, so each result is shown for exactly one cycle
module input_restricted_deque (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  idq_pkg::cmd_t     cmd,
	output logic              done,
	output idq_pkg::result_t  result
);
	import idq_pkg::*;

	logic              accept;
	mem_req_t          req;
	step_t             step;
	step_t             step_s1;
	logic [DATA_W-1:0] rdata;

	// no multi-cycle work: a new transaction can enter every cycle
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// head/tail/count logic, decides the store access and status at accept
	idq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cmd    (cmd),
		.req    (req),
		.step   (step)
	);

	// entry store; a write at one edge is visible to a read issued the
	// next cycle, and only one access happens per cycle, so no forwarding
	idq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (req.we),
		.re    (req.re),
		.addr  (req.addr),
		.wdata (req.wdata),
		.rdata (rdata)
	);

	// result stage lines up with the registered read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1 <= '0;
		end else begin
			step_s1 <= step;
		end
	end

	assign done = step_s1.valid;

	always_comb begin
		result.status   = step_s1.status;
		result.is_empty = step_s1.is_empty;
		result.is_full  = step_s1.is_full;
		if (step_s1.use_mem) begin
			result.data_out = rdata;
		end else if (step_s1.status == ST_UNDERFLOW) begin
			// underflow reports all ones
			result.data_out = '1;
		end else begin
			result.data_out = '0;
		end
	end

endmodule

@@ rtl/idq_chk.sv @@
module idq_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input idq_pkg::result_t  result
);
	import idq_pkg::*;

	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted transaction gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without a transaction");

	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_UNDERFLOW) |->
		(result.data_out == -32'sd1 && result.is_empty))
		else $error("bad underflow result");

	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_OVERFLOW) |->
		(result.data_out == 32'sd0 && result.is_full))
		else $error("bad overflow result");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.is_empty && result.is_full))
		else $error("empty and full together");

endmodule

bind input_restricted_deque idq_chk u_idq_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

@@ tb/input_restricted_deque_test.sv @@
module input_restricted_deque_test;
	import idq_pkg::*;

	// value returned by a remove or a peek on an empty queue
	localparam logic signed [DATA_W-1:0] EMPTY_READ = -1;
	localparam logic signed [DATA_W-1:0] MAX_POS    = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] MIN_NEG    = 32'sh8000_0000;
	localparam int RANDOM_BLOCKS = 15;
	localparam int BLOCK_ITEMS   = 60;

	// fill-biased, drain-biased or balanced random blocks
	typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

	// one directed transaction, with its result typed in when it is obvious
	typedef struct {
		op_t                      op;
		logic signed [DATA_W-1:0] data;
		bit                       given;
		result_t                  res;
	} row_t;

	// typed-in result travelling with a transaction until it is accepted
	typedef struct {
		bit      given;
		result_t res;
	} hint_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	logic    done;
	result_t result;

	input_restricted_deque dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	// shadow deque: circular store, front and rear indexes, item count
	logic signed [DATA_W-1:0] slots [DEPTH];
	logic [ADDR_W-1:0]        front_idx;
	logic [ADDR_W-1:0]        rear_idx;
	logic [CNT_W-1:0]         held;

	result_t pending_results [$];
	hint_t   hints [$];
	row_t    script [$];

	int  fails;
	bit  no_idle;
	int  n_insert, n_pop_front, n_pop_rear, n_peek;
	int  n_overflow, n_underflow, n_full;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog; a correct run needs well under a tenth of this
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [ADDR_W-1:0] step_up(input logic [ADDR_W-1:0] i);
		return (i == ADDR_W'(DEPTH - 1)) ? '0 : i + ADDR_W'(1);
	endfunction

	function automatic logic [ADDR_W-1:0] step_down(input logic [ADDR_W-1:0] i);
		return (i == '0) ? ADDR_W'(DEPTH - 1) : i - ADDR_W'(1);
	endfunction

	// advance the shadow deque by one transaction and return its result
	function automatic result_t deque_step(input cmd_t c);
		result_t r;
		r.data_out = '0;
		r.status   = ST_OK;
		if (c.op == OP_INSERT) begin
			// a full queue refuses the item and stays as it is
			if (held == CNT_W'(DEPTH)) begin
				r.status = ST_OVERFLOW;
			end else begin
				slots[rear_idx] = c.data_in;
				rear_idx = step_up(rear_idx);
				held++;
			end
		end else if (held == '0) begin
			// any read of an empty queue gives all ones and underflow
			r.data_out = EMPTY_READ;
			r.status   = ST_UNDERFLOW;
		end else begin
			case (c.op)
				OP_POP_FRONT: begin
					r.data_out = slots[front_idx];
					front_idx = step_up(front_idx);
					held--;
				end
				OP_POP_REAR: begin
					// rear index points past the last item, step back first
					rear_idx = step_down(rear_idx);
					r.data_out = slots[rear_idx];
					held--;
				end
				default: begin
					r.data_out = slots[front_idx];
				end
			endcase
		end
		r.is_empty = (held == '0);
		r.is_full  = (held == CNT_W'(DEPTH));
		return r;
	endfunction

	function automatic void row_known(input op_t o, input logic signed [DATA_W-1:0] d,
			input logic signed [DATA_W-1:0] dout, input status_t st, input logic e,
			input logic f);
		row_t r;
		r.op = o;
		r.data = d;
		r.given = 1'b1;
		r.res.data_out = dout;
		r.res.status = st;
		r.res.is_empty = e;
		r.res.is_full = f;
		script.push_back(r);
	endfunction

	function automatic void row_checked(input op_t o, input logic signed [DATA_W-1:0] d);
		row_t r;
		r.op = o;
		r.data = d;
		r.given = 1'b0;
		r.res = '0;
		script.push_back(r);
	endfunction

	// mostly random words, now and then one of the extremes
	function automatic logic signed [DATA_W-1:0] pick_value();
		logic signed [DATA_W-1:0] v;
		v = $urandom();
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: v = MAX_POS;
				1: v = MIN_NEG;
				2: v = '0;
				default: v = EMPTY_READ;
			endcase
		end
		return v;
	endfunction

	function automatic op_t pick_op(input mix_t mix);
		int insert_pct;
		op_t o;
		insert_pct = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 25 : 50;
		if ($urandom_range(0, 99) < insert_pct) begin
			o = OP_INSERT;
		end else begin
			case ($urandom_range(0, 2))
				0: o = OP_POP_FRONT;
				1: o = OP_POP_REAR;
				default: o = OP_PEEK;
			endcase
		end
		return o;
	endfunction

	// present one transaction after a random gap and hold it until accepted;
	// called right after a rising edge, start is touched at most once per edge
	task automatic issue(input op_t o, input logic signed [DATA_W-1:0] d, input bit given,
			input result_t res);
		int gap;
		hint_t h;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		h.given = given;
		h.res = res;
		hints.push_back(h);
		start <= 1'b1;
		cmd.op <= o;
		cmd.data_in <= d;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// hold the sender off until every outstanding result has been seen
	task automatic wait_for_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic compare_result(input result_t want, input result_t got);
		if (got.data_out !== want.data_out) begin
			$error("data_out: expected %0d, got %0d", want.data_out, got.data_out);
			fails++;
		end
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			fails++;
		end
		if (got.is_empty !== want.is_empty) begin
			$error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
			fails++;
		end
		if (got.is_full !== want.is_full) begin
			$error("is_full: expected %0b, got %0b", want.is_full, got.is_full);
			fails++;
		end
	endtask

	// result check first, then the transaction accepted at this same edge
	always @(posedge clk) begin
		result_t want;
		hint_t h;
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("result strobe with no transaction outstanding");
					fails++;
				end else begin
					compare_result(pending_results.pop_front(), result);
				end
			end
			if (start && !busy) begin
				want = deque_step(cmd);
				case (cmd.op)
					OP_INSERT:    n_insert++;
					OP_POP_FRONT: n_pop_front++;
					OP_POP_REAR:  n_pop_rear++;
					default:      n_peek++;
				endcase
				if (want.status == ST_OVERFLOW) n_overflow++;
				if (want.status == ST_UNDERFLOW) n_underflow++;
				if (cmd.op == OP_INSERT && want.status == ST_OK && want.is_full) n_full++;
				// a typed-in row overrides the shadow deque's answer
				h = hints.pop_front();
				if (h.given) want = h.res;
				pending_results.push_back(want);
			end
		end
	end

	initial begin
		mix_t mix;
		int   fill_left;
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= '0;
		no_idle = 1'b0;
		fails = 0;
		held = '0;
		front_idx = '0;
		rear_idx = '0;
		{n_insert, n_pop_front, n_pop_rear, n_peek} = '0;
		{n_overflow, n_underflow, n_full} = '0;

		// directed rows: empty reads after reset, extremes at both ends,
		// mixed removal order, emptying the queue again
		row_known(OP_PEEK,      '0,      EMPTY_READ, ST_UNDERFLOW, 1'b1, 1'b0);
		row_known(OP_POP_FRONT, MAX_POS, EMPTY_READ, ST_UNDERFLOW, 1'b1, 1'b0);
		row_known(OP_POP_REAR,  MIN_NEG, EMPTY_READ, ST_UNDERFLOW, 1'b1, 1'b0);
		row_known(OP_INSERT,    MAX_POS, '0,         ST_OK,        1'b0, 1'b0);
		row_known(OP_INSERT,    MIN_NEG, '0,         ST_OK,        1'b0, 1'b0);
		row_checked(OP_INSERT,    EMPTY_READ);
		row_checked(OP_INSERT,    '0);
		row_known(OP_PEEK,      '0,      MAX_POS,    ST_OK,        1'b0, 1'b0);
		row_checked(OP_POP_REAR,  '0);
		row_known(OP_POP_FRONT, '0,      MAX_POS,    ST_OK,        1'b0, 1'b0);
		row_checked(OP_POP_REAR,  '0);
		row_known(OP_PEEK,      '0,      MIN_NEG,    ST_OK,        1'b0, 1'b0);
		row_known(OP_POP_FRONT, '0,      MIN_NEG,    ST_OK,        1'b1, 1'b0);
		row_known(OP_POP_REAR,  '0,      EMPTY_READ, ST_UNDERFLOW, 1'b1, 1'b0);
		row_checked(OP_INSERT,    32'sh5555_5555);
		row_checked(OP_INSERT,    32'shaaaa_aaaa);
		row_checked(OP_POP_REAR,  '0);
		row_checked(OP_POP_REAR,  '0);
		row_checked(OP_PEEK,      '0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) issue(script[i].op, script[i].data, script[i].given, script[i].res);

		// fill to the brim with the indexes off zero, knock on the full queue,
		// then empty it from both ends so the indexes wrap
		for (int i = 0; i < DEPTH; i++) issue(OP_INSERT, pick_value(), 1'b0, '0);
		issue(OP_INSERT, pick_value(), 1'b0, '0);
		issue(OP_PEEK, '0, 1'b0, '0);
		issue(OP_POP_REAR, '0, 1'b0, '0);
		issue(OP_INSERT, pick_value(), 1'b0, '0);
		issue(OP_INSERT, pick_value(), 1'b0, '0);
		for (int i = 0; i < DEPTH; i++)
			issue(i[0] ? OP_POP_REAR : OP_POP_FRONT, pick_value(), 1'b0, '0);
		issue(OP_POP_FRONT, '0, 1'b0, '0);
		wait_for_results();

		// random blocks; fill and drain bias sweep the count across its range,
		// every fourth block runs back to back with no idle cycles
		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			case (blk % 3)
				0: mix = MIX_FILL;
				1: mix = MIX_BALANCED;
				default: mix = MIX_DRAIN;
			endcase
			no_idle = (blk % 4 == 3);
			fill_left = BLOCK_ITEMS;
			while (fill_left > 0) begin
				issue(pick_op(mix), pick_value(), 1'b0, '0);
				fill_left--;
			end
			// pause the sender now and then, and always halfway through
			if (blk == RANDOM_BLOCKS / 2 || $urandom_range(0, 2) == 0) wait_for_results();
		end
		no_idle = 1'b0;

		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		// keep watching to catch any stray strobe
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			fails++;
		end

		$display("covered %0d transactions: %0d inserts, %0d front removals, %0d rear removals, %0d peeks",
			n_insert + n_pop_front + n_pop_rear + n_peek, n_insert, n_pop_front, n_pop_rear,
			n_peek);
		$display("%0d overflows, %0d underflows, queue filled up %0d times",
			n_overflow, n_underflow, n_full);
		if (fails == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
